### sv/mep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types, constants and register codes of the escape-time pixel unit.
// ----------------------------------------------------------------------------
package mep_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 26;
	localparam int INDEX_WIDTH_DEF = 12;

	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int ITER_W     = 16;
	localparam int RGB_W      = 24;
	localparam int PAL_IDX_W  = 3;
	localparam int PAL_SIZE   = 8;
	localparam int ESC_R2     = 16;

	localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFFFFFF;

	localparam logic [RGB_W-1:0] PAL_RGB [PAL_SIZE] = '{
		24'h04182B, 24'h5A8C8C, 24'hF2D99D, 24'h738585,
		24'hAB1111, 24'h04182B, 24'h5A8C8C, 24'hF2D99D
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X       = 3'd0,
		REG_STEP_X      = 3'd1,
		REG_MIN_Y       = 3'd2,
		REG_STEP_Y      = 3'd3,
		REG_MAX_ITER    = 3'd4,
		REG_FIXED_COLOR = 3'd5
	} cfg_idx_t;

	localparam logic [CFG_W-1:0]  MIN_X_RST       = 32'hF800_0000;
	localparam logic [CFG_W-1:0]  STEP_X_RST      = 32'h0004_0000;
	localparam logic [CFG_W-1:0]  MIN_Y_RST       = 32'hF800_0000;
	localparam logic [CFG_W-1:0]  STEP_Y_RST      = 32'h0004_0000;
	localparam logic [ITER_W-1:0] MAX_ITER_RST    = 16'd256;
	localparam logic [RGB_W-1:0]  FIXED_COLOR_RST = 24'h000000;

	typedef struct packed {
		logic [CFG_W-1:0]  min_x;
		logic [CFG_W-1:0]  step_x;
		logic [CFG_W-1:0]  min_y;
		logic [CFG_W-1:0]  step_y;
		logic [ITER_W-1:0] max_iter;
		logic [RGB_W-1:0]  fixed_color;
	} cfg_regs_t;

	typedef struct packed {
		logic start;
		logic c_prod;
		logic c_sum;
		logic mul;
		logic step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic zero_limit;
		logic escape;
		logic at_limit;
		logic out_free;
	} ctrl_stat_t;

endpackage

### sv/mep_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep channel interfaces
// Valid/ready channels for pixel requests and escape-time results.
// ----------------------------------------------------------------------------
interface mep_pix_in_if #(
	parameter int INDEX_WIDTH = mep_pkg::INDEX_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [INDEX_WIDTH-1:0] pixel_row;
	logic [INDEX_WIDTH-1:0] pixel_col;

	modport source(output valid, output pixel_row, output pixel_col, input ready);
	modport sink(input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface mep_res_out_if;
	import mep_pkg::*;

	logic              valid;
	logic              ready;
	logic [ITER_W-1:0] iter_count;
	logic              in_set;
	logic [RGB_W-1:0]  pixel_rgb;

	modport source(output valid, output iter_count, output in_set, output pixel_rgb,
		input ready);
	modport sink(input valid, input iter_count, input in_set, input pixel_rgb,
		output ready);
endinterface

### sv/mep_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module mep_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mep_pkg::CFG_W-1:0]      cfg_wdata,
	output mep_pkg::cfg_regs_t             cfg
);
	import mep_pkg::*;

	cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x       <= MIN_X_RST;
			cfg_q.step_x      <= STEP_X_RST;
			cfg_q.min_y       <= MIN_Y_RST;
			cfg_q.step_y      <= STEP_Y_RST;
			cfg_q.max_iter    <= MAX_ITER_RST;
			cfg_q.fixed_color <= FIXED_COLOR_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_MIN_X:       cfg_q.min_x       <= cfg_wdata;
				REG_STEP_X:      cfg_q.step_x      <= cfg_wdata;
				REG_MIN_Y:       cfg_q.min_y       <= cfg_wdata;
				REG_STEP_Y:      cfg_q.step_y      <= cfg_wdata;
				REG_MAX_ITER:    cfg_q.max_iter    <= cfg_wdata[ITER_W-1:0];
				REG_FIXED_COLOR: cfg_q.fixed_color <= cfg_wdata[RGB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/mep_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_datapath
// Point forming, complex square-and-add step, escape test, colour and
// result register.
// ----------------------------------------------------------------------------
module mep_datapath #(
	parameter int COORD_WIDTH = mep_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = mep_pkg::FRAC_BITS_DEF,
	parameter int INDEX_WIDTH = mep_pkg::INDEX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mep_pkg::cfg_regs_t          cfg,
	input  mep_pkg::ctrl_cmd_t          cmd,
	output mep_pkg::ctrl_stat_t         stat,
	input  logic [INDEX_WIDTH-1:0]      pixel_row,
	input  logic [INDEX_WIDTH-1:0]      pixel_col,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [mep_pkg::ITER_W-1:0]  iter_count,
	output logic                        in_set,
	output logic [mep_pkg::RGB_W-1:0]   pixel_rgb
);
	import mep_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int PW  = 2 * CW;
	localparam int SW  = 2 * CW + 2;
	localparam int PRW = CW + INDEX_WIDTH + 1;
	localparam int EXW = (CW > CFG_W) ? CW : CFG_W;

	localparam logic signed [SW-1:0] SAT_HI = (SW'(1) << (CW - 1)) - SW'(1);
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [SW-1:0] LIM2   = SW'(ESC_R2) << (2 * FRAC_BITS);

	function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[CW-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[CW-1:0];
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [CW-1:0] to_coord(input logic [CFG_W-1:0] v);
		logic [EXW-1:0] e;
		e = EXW'(v);
		return $signed(e[CW-1:0]);
	endfunction

	logic [INDEX_WIDTH-1:0] row_q, col_q;
	logic signed [PRW-1:0]  prod_x_q, prod_y_q;
	logic signed [CW-1:0]   c_re_q, c_im_q;
	logic signed [CW-1:0]   zr_q, zi_q;
	logic signed [PW-1:0]   rr_q, ii_q, ri_q;
	logic [ITER_W-1:0]      count_q;
	logic [ITER_W-1:0]      count_inc;

	logic                   out_valid_q;
	logic [ITER_W-1:0]      out_count_q;
	logic                   out_in_set_q;
	logic [RGB_W-1:0]       out_rgb_q;

	logic signed [SW-1:0]   mag2;
	logic signed [SW-1:0]   re_full, im_full;
	logic signed [SW-1:0]   c_re_full, c_im_full;
	logic                   escape;
	logic                   done_in_set;
	logic [RGB_W-1:0]       pal_rgb;
	logic [RGB_W-1:0]       rgb_sel;

	// point of the pixel
	assign c_re_full = SW'(prod_x_q) + SW'(to_coord(cfg.min_x));
	assign c_im_full = SW'(prod_y_q) + SW'(to_coord(cfg.min_y));

	// escape test and next z
	assign mag2    = SW'(rr_q) + SW'(ii_q);
	assign escape  = mag2 > LIM2;
	assign re_full = ((SW'(rr_q) - SW'(ii_q)) >>> FRAC_BITS) + SW'(c_re_q);
	assign im_full = ((SW'(ri_q) <<< 1) >>> FRAC_BITS) + SW'(c_im_q);

	assign count_inc = count_q + ITER_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q <= pixel_row;
			col_q <= pixel_col;
		end
		if (cmd.c_prod) begin
			prod_x_q <= $signed({1'b0, col_q}) * to_coord(cfg.step_x);
			prod_y_q <= $signed({1'b0, row_q}) * to_coord(cfg.step_y);
		end
		if (cmd.c_sum) begin
			c_re_q <= sat_c(c_re_full);
			c_im_q <= sat_c(c_im_full);
		end
		if (cmd.mul) begin
			rr_q <= zr_q * zr_q;
			ii_q <= zi_q * zi_q;
			ri_q <= zr_q * zi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end else if (cmd.start) begin
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end else if (cmd.step && !escape) begin
			zr_q    <= sat_c(re_full);
			zi_q    <= sat_c(im_full);
			count_q <= count_inc;
		end
	end

	assign stat.zero_limit = cfg.max_iter == '0;
	assign stat.escape     = escape;
	assign stat.at_limit   = count_inc == cfg.max_iter;
	assign stat.out_free   = !out_valid_q || res_ready;

	// colour pick
	assign done_in_set = count_q == cfg.max_iter;
	assign pal_rgb     = PAL_RGB[count_q[PAL_IDX_W-1:0]];

	always_comb begin
		if (cfg.fixed_color == '0) begin
			rgb_sel = pal_rgb;
		end else if (done_in_set) begin
			rgb_sel = cfg.fixed_color;
		end else begin
			rgb_sel = WHITE_RGB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_count_q  <= count_q;
			out_in_set_q <= done_in_set;
			out_rgb_q    <= rgb_sel;
		end
	end

	assign res_valid  = out_valid_q;
	assign iter_count = out_count_q;
	assign in_set     = out_in_set_q;
	assign pixel_rgb  = out_rgb_q;

`ifndef SYNTHESIS
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !escape && !cmd.start) |=> count_q == $past(count_inc))
		else $error("step count did not advance by one");

	a_load_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load_out))
		else $error("result raised without a load");

	a_in_set_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_in_set_q) |-> out_count_q == cfg.max_iter)
		else $error("in-set flag with count below the limit");
`endif

endmodule

### sv/mep_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_ctrl
// Sequencer: point forming, multiply / step loop, result hand-off.
// ----------------------------------------------------------------------------
module mep_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mep_pkg::ctrl_stat_t  stat,
	output mep_pkg::ctrl_cmd_t   cmd
);
	import mep_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CPROD  = 6'b000010,
		S_CSUM   = 6'b000100,
		S_MUL    = 6'b001000,
		S_STEP   = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_CPROD;
				end
			end
			S_CPROD: begin
				cmd.c_prod = 1'b1;
				state_d    = S_CSUM;
			end
			S_CSUM: begin
				cmd.c_sum = 1'b1;
				state_d   = stat.zero_limit ? S_FINISH : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = (stat.escape || stat.at_limit) ? S_FINISH : S_MUL;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded over a waiting result");

	a_loop_on: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && !stat.escape && !stat.at_limit) |=> state_q == S_MUL)
		else $error("loop left before escape or limit");

	a_zero_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CSUM && stat.zero_limit) |=> state_q == S_FINISH)
		else $error("zero step limit ran a step");
`endif

endmodule

### sv/mandelbrot_escape_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time unit: one pixel request in, step count, in-set flag and
// colour out.
//
//   channel   dir  handshake     transaction payload
//   pix_in    in   valid/ready   pixel_row, pixel_col
//   res_out   out  valid/ready   iter_count, in_set, pixel_rgb
//   cfg       in   cfg_wen       cfg_index, cfg_wdata
//
// One pixel is in flight at a time; pix_in is ready only while the
// sequencer is idle.
// Each step evaluated is a multiply state (S_MUL) followed by a
// compare-and-update state (S_STEP) of the sequencer.
// The result register lets the next pixel start while a result waits;
// a stall on res_out holds the sequencer only when a second result is done.
// arst_n clears the sequencer, the result valid and the configuration
// registers to their defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel #(
	parameter int COORD_WIDTH = mep_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = mep_pkg::FRAC_BITS_DEF,
	parameter int INDEX_WIDTH = mep_pkg::INDEX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mep_pkg::CFG_W-1:0]      cfg_wdata,
	mep_pix_in_if.sink                     pix_in,
	mep_res_out_if.source                  res_out
);
	import mep_pkg::*;

	cfg_regs_t  cfg;
	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;
	logic       in_ready;

	mep_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mep_datapath #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.stat       (stat),
		.pixel_row  (pix_in.pixel_row),
		.pixel_col  (pix_in.pixel_col),
		.res_valid  (res_out.valid),
		.res_ready  (res_out.ready),
		.iter_count (res_out.iter_count),
		.in_set     (res_out.in_set),
		.pixel_rgb  (res_out.pixel_rgb)
	);

	assign pix_in.ready = in_ready;

endmodule
